// File: hdl/tdm_pkg.sv
package tdm_pkg;

    localparam int MaxTilesDefault = 2048;

    typedef enum logic [1:0] {
        KIND_MAP   = 2'd0,
        KIND_ROW   = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_MIXED   = 2'd0,
        ERR_PALETTE = 2'd1,
        ERR_FULL    = 2'd2
    } t_err;

    typedef enum logic {
        CFG_DEDUP = 1'b0,
        CFG_BASE  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        start_image;
        logic [63:0] pixel_row;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] map_word;
        logic [31:0] tile_row;
        logic [1:0]  error_code;
        logic        last;
    } t_out;

    // Classified tile handed from the front end to the back end
    typedef struct packed {
        logic           start_image;
        logic           err;
        logic [1:0]     err_code;
        logic [1:0]     palette;
        logic [255:0]   rows;
    } t_job;

    function automatic logic [31:0] rev_nib(input logic [31:0] v);
        logic [31:0] r;
        for (int k = 0; k < 8; k++) begin
            r[4*k +: 4] = v[4*(7-k) +: 4];
        end
        return r;
    endfunction

endpackage

// File: hdl/tdm_front.sv
module tdm_front
    import tdm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_job o_job
);

    logic [2:0]   r_row;
    logic [3:0]   r_pal;
    logic         r_mixed;
    logic         r_start;
    logic [255:0] r_rows;
    logic         r_job_valid;
    t_job         r_job;

    logic [2:0]  n_row;
    logic [3:0]  pal;
    logic        mixed;
    logic [31:0] packed_row;

    // Hold input only while a finished tile cannot leave
    assign o_ready     = !r_job_valid || i_job_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign n_row       = i_data.start_image ? 3'd0 : r_row;

    always_comb begin
        pal   = (n_row == 3'd0) ? i_data.pixel_row[7:4] : r_pal;
        mixed = (n_row == 3'd0) ? 1'b0 : r_mixed;
        for (int k = 0; k < 8; k++) begin
            if (i_data.pixel_row[8*k+4 +: 4] != pal) mixed = 1'b1;
            packed_row[4*(7-k) +: 4] = i_data.pixel_row[8*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= 3'd0;
            r_pal       <= 4'd0;
            r_mixed     <= 1'b0;
            r_start     <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            // Raise the queue entry on the last row, drop it once taken
            if (i_valid && o_ready && n_row == 3'd7) r_job_valid <= 1'b1;
            else if (i_job_ready) r_job_valid <= 1'b0;
            if (i_valid && o_ready) begin
                r_pal   <= pal;
                r_mixed <= mixed;
                r_rows[32*n_row +: 32] <= packed_row;
                if (n_row == 3'd0) r_start <= i_data.start_image;
                if (n_row == 3'd7) begin
                    r_row             <= 3'd0;
                    r_job.start_image <= r_start && !i_data.start_image;
                    r_job.err         <= mixed || (pal > 4'd3);
                    r_job.err_code    <= mixed ? ERR_MIXED : ERR_PALETTE;
                    r_job.palette     <= pal[1:0];
                    r_job.rows        <= {packed_row, r_rows[223:0]};
                end else begin
                    r_row <= n_row + 3'd1;
                end
            end
        end
    end

endmodule

// File: hdl/tdm_back.sv
module tdm_back
    import tdm_pkg::*;
#(
    parameter int MAX_TILES = MaxTilesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    input  logic        i_dedup,
    input  logic [15:0] i_base,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data
);

    localparam int IdxW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CntW = $clog2(MAX_TILES + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_ROWS   = 5'b00100,
        S_MAP    = 5'b01000,
        S_ERR    = 5'b10000
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_scan;
    logic [2:0]      r_rd;
    logic [2:0]      r_wr;
    logic            r_hit_p, r_hit_h, r_hit_v, r_hit_hv;
    logic            r_rd_ok;
    logic [1:0]      r_flags;
    logic [IdxW-1:0] r_idx;
    logic [1:0]      r_ecode;
    logic [31:0]     r_rdata;
    logic [2:0]      r_rdrow;
    t_job            r_job;
    logic            r_ovalid;
    t_out            r_out;

    logic [31:0] mem [MAX_TILES*8];
    logic [IdxW+2:0] rd_addr;
    logic        out_free;
    logic        emit;
    logic [31:0] cur [8];
    logic        hp, hh, hv, hhv;

    assign out_free    = !r_ovalid || i_ready;
    assign emit        = out_free && (r_state inside {S_ROWS, S_MAP, S_ERR});
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_job_ready = (r_state == S_IDLE);
    assign rd_addr     = {r_scan[IdxW-1:0], r_rd};

    always_comb begin
        for (int r = 0; r < 8; r++) cur[r] = r_job.rows[32*r +: 32];
        hp  = r_hit_p  && (r_rdata == cur[r_rdrow]);
        hh  = r_hit_h  && (r_rdata == rev_nib(cur[r_rdrow]));
        hv  = r_hit_v  && (r_rdata == cur[3'd7 - r_rdrow]);
        hhv = r_hit_hv && (r_rdata == rev_nib(cur[3'd7 - r_rdrow]));
    end

    // Memory: one read port for the search, one write port for new tiles
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (r_state == S_ROWS && out_free)
            mem[{r_count[IdxW-1:0], r_wr}] <= cur[r_wr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            // Load a new beat when one is made, otherwise drop a taken one
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job  <= i_job;
                        r_scan <= '0;
                        r_rd   <= 3'd0;
                        r_rd_ok <= 1'b0;
                        r_wr   <= 3'd0;
                        r_hit_p <= 1'b1; r_hit_h <= 1'b1;
                        r_hit_v <= 1'b1; r_hit_hv <= 1'b1;
                        if (i_job.start_image) r_count <= '0;
                        if (i_job.err) begin
                            r_ecode <= i_job.err_code;
                            r_state <= S_ERR;
                        end else if (i_dedup &&
                                     (i_job.start_image ? 1'b0 : (r_count != '0))) begin
                            r_state <= S_SEARCH;
                        end else if ((i_job.start_image ? '0 : r_count) >= CntW'(MAX_TILES)) begin
                            r_ecode <= ERR_FULL;
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_ROWS;
                        end
                    end
                end
                S_SEARCH: begin
                    // Issue reads one row a cycle, compare in the cycle after the read
                    r_rd    <= r_rd + 3'd1;
                    r_rdrow <= r_rd;
                    r_rd_ok <= 1'b1;
                    if (r_rd == 3'd7) r_scan <= r_scan + CntW'(1);
                    if (r_rd_ok) begin
                        if (r_rdrow == 3'd7) begin
                            if (hp || hh || hv || hhv) begin
                                r_idx   <= r_scan[IdxW-1:0] - IdxW'(1);
                                r_flags <= hp ? 2'b00 : hh ? 2'b01 : hv ? 2'b10 : 2'b11;
                                r_state <= S_MAP;
                            end else if (r_scan == r_count) begin
                                if (r_count >= CntW'(MAX_TILES)) begin
                                    r_ecode <= ERR_FULL;
                                    r_state <= S_ERR;
                                end else begin
                                    r_state <= S_ROWS;
                                end
                            end else begin
                                r_hit_p <= 1'b1; r_hit_h <= 1'b1;
                                r_hit_v <= 1'b1; r_hit_hv <= 1'b1;
                            end
                        end else begin
                            r_hit_p <= hp; r_hit_h <= hh; r_hit_v <= hv; r_hit_hv <= hhv;
                        end
                    end
                end
                S_ROWS: begin
                    if (out_free) begin
                        r_out <= '{kind: KIND_ROW, map_word: 16'd0,
                                   tile_row: cur[r_wr], error_code: 2'd0, last: 1'b0};
                        r_wr <= r_wr + 3'd1;
                        if (r_wr == 3'd7) begin
                            r_idx   <= r_count[IdxW-1:0];
                            r_flags <= 2'b00;
                            r_count <= r_count + CntW'(1);
                            r_state <= S_MAP;
                        end
                    end
                end
                S_MAP: begin
                    if (out_free) begin
                        r_out <= '{kind: KIND_MAP,
                                   map_word: ({1'b0, r_job.palette, r_flags, 11'd0}
                                              | 16'(r_idx) | i_base),
                                   tile_row: 32'd0, error_code: 2'd0, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out <= '{kind: KIND_ERROR, map_word: 16'd0, tile_row: 32'd0,
                                   error_code: r_ecode, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/tile_dedup_map_builder.sv
// Tile deduplication and map builder.
// Input channel: one beat per tile row (eight 8-bit pixels). Rows 0..6 give
// no result; row 7 produces either an error beat, a map word beat after a
// matching stored tile, or eight packed row beats followed by a map word.
// The last field marks the final beat of each tile's output.
// Rows are taken one per cycle by the front end unless a finished tile is
// held in its one-entry queue; a finished tile waits there while the back
// end searches. The search reads one stored row per cycle from the tile
// memory port.
// Reset clears the tile count and row counter; the memory needs no clear.
// A stalled receiver holds the output register and stalls the back end,
// then the queue, then input acceptance.
// Configuration: write enable, index (0 dedup enable, 1 base flags), data.
module tile_dedup_map_builder
    import tdm_pkg::*;
#(
    parameter int MAX_TILES = MaxTilesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_dedup;
    logic [15:0] r_base;
    logic        job_valid, job_ready;
    t_job        job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup <= 1'b1;
            r_base  <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEDUP: r_dedup <= i_cfg_data[0];
                CFG_BASE:  r_base  <= i_cfg_data;
                default:   r_base  <= r_base;
            endcase
        end
    end

    tdm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    tdm_back #(.MAX_TILES(MAX_TILES)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .i_dedup(r_dedup), .i_base(r_base),
        .o_valid, .i_ready, .o_data
    );

endmodule

// File: hdl/tdm_checker.sv
module tdm_checker
    import tdm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat dropped while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.kind != 2'd3)
        else $error("bad kind");

    a_rowlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_ROW |-> !o_data.last)
        else $error("row beat marked last");

    a_maplast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.kind == KIND_MAP || o_data.kind == KIND_ERROR) |-> o_data.last)
        else $error("map or error beat not last");

endmodule

bind tile_dedup_map_builder tdm_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);
